// ----- design/vlq_pkg.sv -----
`timescale 1ns / 1ps
package vlq_pkg;

	localparam int IN_FIELD_W = 11;
	localparam int NUM_FIELDS = 8;
	localparam int IN_DATA_W = 88;
	localparam int OUT_W = 32;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 2;
	localparam int USER_DEG = 0;
	localparam int USER_SAT = 1;
	localparam int FRAC_BITS = 24;
	localparam int QUO_BITS = 34;
	localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

	localparam int LINE_P [4] = '{0, 2, 0, 1};
	localparam int LINE_Q [4] = '{1, 3, 2, 3};

	typedef logic [IN_FIELD_W-1:0] field_t;

endpackage

// ----- design/vanishing_line_from_quad_top.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Beat payload
// s_*     | in  | tdata[87:0]: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (11 bits each)
// m_*     | out | tdata[63:0]: line_a, line_b; tuser[1:0]: degenerate, saturated
// One quad per cycle sustained while the output is not back-pressured.
// Front: side lines, vanishing points and line terms through six stages with split multipliers.
// Back: two restoring dividers, one quotient bit per stage over 34 stages, plus round/clamp.
// A four-entry queue between front and back lets each stall on its own.
// Reset clears all valid bits and queue pointers; no clearing pass.
module vanishing_line_from_quad_top #(
	parameter int COORD_BITS = 11
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [vlq_pkg::IN_DATA_W-1:0]  s_tdata,  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [vlq_pkg::OUT_DATA_W-1:0] m_tdata,  // line_a, line_b
	output logic [vlq_pkg::OUT_USER_W-1:0] m_tuser   // degenerate, saturated
);
	import vlq_pkg::*;

	localparam int LW = 6*COORD_BITS + 7;

	logic          f_valid, f_ready;
	logic [LW-1:0] f_la, f_lb, f_lc;
	logic [3*LW-1:0] q_rd;
	logic          q_full, q_empty, b_ready;
	logic [OUT_W-1:0] line_a, line_b;
	logic          degenerate, saturated;

	vlq_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.out_valid(f_valid), .out_ready(f_ready),
		.la(f_la), .lb(f_lb), .lc(f_lc)
	);

	assign f_ready = ~q_full;

	vlq_fifo #(.WIDTH(3*LW), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(f_valid & ~q_full), .wr_data({f_lc, f_lb, f_la}),
		.pop(~q_empty & b_ready), .rd_data(q_rd),
		.full(q_full), .empty(q_empty)
	);

	vlq_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(~q_empty), .in_ready(b_ready),
		.la(q_rd[LW-1:0]), .lb(q_rd[2*LW-1:LW]), .lc(q_rd[3*LW-1:2*LW]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.line_a(line_a), .line_b(line_b),
		.degenerate(degenerate), .saturated(saturated)
	);

	assign m_tdata = {line_b, line_a};
	assign m_tuser = {saturated, degenerate};

endmodule

// ----- design/vlq_front.sv -----
`timescale 1ns / 1ps
module vlq_front #(
	parameter int COORD_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vlq_pkg::IN_DATA_W-1:0] in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [6*COORD_BITS+6:0]       la,
	output logic [6*COORD_BITS+6:0]       lb,
	output logic [6*COORD_BITS+6:0]       lc
);
	import vlq_pkg::*;

	localparam int N = COORD_BITS;
	localparam int VW = 3*N + 3;
	localparam int H = (VW + 1) / 2;
	localparam int HW = VW - H;
	localparam int PW = 2*VW;
	localparam int LW = PW + 1;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [N-1:0] crd [NUM_FIELDS];
	logic [N-1:0] c_s1 [NUM_FIELDS];

	logic signed [N:0]     lx_s2 [4];
	logic signed [N:0]     ly_s2 [4];
	logic signed [2*N:0]   lz_s2 [4];
	logic signed [N:0]     lx_c [4];
	logic signed [N:0]     ly_c [4];
	logic signed [2*N:0]   lz_c [4];

	logic signed [VW-1:0] vx_s3 [2];
	logic signed [VW-1:0] vy_s3 [2];
	logic signed [VW-1:0] vz_s3 [2];
	logic signed [VW-1:0] vx_c [2];
	logic signed [VW-1:0] vy_c [2];
	logic signed [VW-1:0] vz_c [2];

	logic signed [VW-1:0] opa [6];
	logic signed [VW-1:0] opb [6];

	logic signed [2*HW-1:0]  hh_s4 [6];
	logic signed [HW+H:0]    hl_s4 [6];
	logic signed [HW+H:0]    lh_s4 [6];
	logic [2*H-1:0]          ll_s4 [6];
	logic signed [2*HW-1:0]  hh_c [6];
	logic signed [HW+H:0]    hl_c [6];
	logic signed [HW+H:0]    lh_c [6];
	logic [2*H-1:0]          ll_c [6];

	logic signed [PW-1:0] pr_s5 [6];
	logic signed [PW-1:0] pr_c [6];

	logic signed [LW-1:0] la_s6, lb_s6, lc_s6;
	logic signed [LW-1:0] e_pr [6];

	assign en = ~v_s6 | out_ready;
	assign in_ready = en;

	for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_fld
		field_t raw;
		assign raw = in_data[f*IN_FIELD_W +: IN_FIELD_W];
		if (N <= IN_FIELD_W) begin : g_cut
			assign crd[f] = raw[N-1:0];
		end else begin : g_ext
			assign crd[f] = {{(N-IN_FIELD_W){1'b0}}, raw};
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_side
		localparam int PA = LINE_P[j];
		localparam int PB = LINE_Q[j];
		logic [2*N-1:0] pxy, pyx;
		assign pxy = c_s1[2*PA] * c_s1[2*PB+1];
		assign pyx = c_s1[2*PA+1] * c_s1[2*PB];
		assign lx_c[j] = $signed({1'b0, c_s1[2*PA+1]}) - $signed({1'b0, c_s1[2*PB+1]});
		assign ly_c[j] = $signed({1'b0, c_s1[2*PB]}) - $signed({1'b0, c_s1[2*PA]});
		assign lz_c[j] = $signed({1'b0, pxy}) - $signed({1'b0, pyx});
	end

	for (genvar m = 0; m < 2; m++) begin : g_vp
		logic signed [3*N+1:0] pxa, pxb, pya, pyb;
		logic signed [2*N+1:0] pza, pzb;
		logic signed [VW-1:0]  exa, exb, eya, eyb, eza, ezb;
		assign pxa = ly_s2[2*m] * lz_s2[2*m+1];
		assign pxb = lz_s2[2*m] * ly_s2[2*m+1];
		assign pya = lz_s2[2*m] * lx_s2[2*m+1];
		assign pyb = lx_s2[2*m] * lz_s2[2*m+1];
		assign pza = lx_s2[2*m] * ly_s2[2*m+1];
		assign pzb = ly_s2[2*m] * lx_s2[2*m+1];
		assign exa = VW'(pxa);
		assign exb = VW'(pxb);
		assign eya = VW'(pya);
		assign eyb = VW'(pyb);
		assign eza = VW'(pza);
		assign ezb = VW'(pzb);
		assign vx_c[m] = exa - exb;
		assign vy_c[m] = eya - eyb;
		assign vz_c[m] = eza - ezb;
	end

	always_comb begin
		opa[0] = vy_s3[0]; opb[0] = vz_s3[1];
		opa[1] = vz_s3[0]; opb[1] = vy_s3[1];
		opa[2] = vz_s3[0]; opb[2] = vx_s3[1];
		opa[3] = vx_s3[0]; opb[3] = vz_s3[1];
		opa[4] = vx_s3[0]; opb[4] = vy_s3[1];
		opa[5] = vy_s3[0]; opb[5] = vx_s3[1];
	end

	for (genvar k = 0; k < 6; k++) begin : g_prod
		logic signed [HW-1:0] ah, bh;
		logic [H-1:0]         al, bl;
		logic signed [PW-1:0] e_hh, e_hl, e_lh, e_ll;
		assign ah = opa[k][VW-1:H];
		assign bh = opb[k][VW-1:H];
		assign al = opa[k][H-1:0];
		assign bl = opb[k][H-1:0];
		assign hh_c[k] = ah * bh;
		assign hl_c[k] = ah * $signed({1'b0, bl});
		assign lh_c[k] = $signed({1'b0, al}) * bh;
		assign ll_c[k] = al * bl;
		assign e_hh = PW'(hh_s4[k]);
		assign e_hl = PW'(hl_s4[k]);
		assign e_lh = PW'(lh_s4[k]);
		assign e_ll = PW'($signed({1'b0, ll_s4[k]}));
		assign pr_c[k] = (e_hh <<< (2*H)) + ((e_hl + e_lh) <<< H) + e_ll;
		assign e_pr[k] = LW'(pr_s5[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= crd;
			lx_s2 <= lx_c;
			ly_s2 <= ly_c;
			lz_s2 <= lz_c;
			vx_s3 <= vx_c;
			vy_s3 <= vy_c;
			vz_s3 <= vz_c;
			hh_s4 <= hh_c;
			hl_s4 <= hl_c;
			lh_s4 <= lh_c;
			ll_s4 <= ll_c;
			pr_s5 <= pr_c;
			la_s6 <= e_pr[0] - e_pr[1];
			lb_s6 <= e_pr[2] - e_pr[3];
			lc_s6 <= e_pr[4] - e_pr[5];
		end
	end

	assign out_valid = v_s6;
	assign la = la_s6;
	assign lb = lb_s6;
	assign lc = lc_s6;

endmodule

// ----- design/vlq_fifo.sv -----
`timescale 1ns / 1ps
module vlq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q, rd_q;

	assign empty = wr_q == rd_q;
	assign full = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign rd_data = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[AW-1:0]] <= wr_data;
	end

endmodule

// ----- design/vlq_back.sv -----
`timescale 1ns / 1ps
module vlq_back #(
	parameter int COORD_BITS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [6*COORD_BITS+6:0]   la,
	input  logic [6*COORD_BITS+6:0]   lb,
	input  logic [6*COORD_BITS+6:0]   lc,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [vlq_pkg::OUT_W-1:0] line_a,
	output logic [vlq_pkg::OUT_W-1:0] line_b,
	output logic                      degenerate,
	output logic                      saturated
);
	import vlq_pkg::*;

	localparam int N = COORD_BITS;
	localparam int LW = 6*N + 7;
	localparam int QW = QUO_BITS;
	localparam int RW = LW + QW - 1;

	logic en;
	logic [LW-1:0] num [2];
	logic [LW-1:0] md;

	logic [RW-1:0] rem_s [2][QW+1];
	logic [QW-1:0] q_s   [2][QW+1];
	logic          ng_s  [2][QW+1];
	logic [LW-1:0] d_s   [QW+1];
	logic          dg_s  [QW+1];
	logic          v_s   [QW+1];

	logic [OUT_W-1:0] res [2];
	logic             sat [2];

	logic             out_valid_q;
	logic [OUT_W-1:0] line_a_q, line_b_q;
	logic             deg_q, sat_q;

	assign en = ~out_valid_q | out_ready;
	assign in_ready = en;

	assign num[0] = la;
	assign num[1] = lb;
	assign md = lc[LW-1] ? LW'(-lc) : lc;

	for (genvar n = 0; n < 2; n++) begin : g_lane
		logic [LW-1:0] mn;
		logic          rnd;
		logic [QW:0]   qr, lim;
		logic [OUT_W-1:0] val;
		assign mn = num[n][LW-1] ? LW'(-num[n]) : num[n];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[n][0] <= {{(RW-LW-FRAC_BITS){1'b0}}, mn, {FRAC_BITS{1'b0}}};
				q_s[n][0] <= '0;
				ng_s[n][0] <= num[n][LW-1] ^ lc[LW-1];
			end
		end

		for (genvar k = 0; k < QW; k++) begin : g_bit
			localparam int I = QW - 1 - k;
			logic [RW-1:0] dsh;
			logic          ge;
			assign dsh = RW'(d_s[k]) << I;
			assign ge = rem_s[n][k] >= dsh;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[n][k+1] <= ge ? rem_s[n][k] - dsh : rem_s[n][k];
					q_s[n][k+1] <= q_s[n][k] | (QW'(ge) << I);
					ng_s[n][k+1] <= ng_s[n][k];
				end
			end
		end

		assign rnd = {rem_s[n][QW][LW-1:0], 1'b0} >= {1'b0, d_s[QW]};
		assign qr = {1'b0, q_s[n][QW]} + (QW+1)'(rnd);
		assign lim = (QW+1)'(ng_s[n][QW] ? SAT_NEG : SAT_POS);
		assign sat[n] = qr > lim;
		assign val = sat[n] ? lim[OUT_W-1:0] : qr[OUT_W-1:0];
		assign res[n] = ng_s[n][QW] ? -val : val;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= md;
			dg_s[0] <= lc == '0;
			for (int k = 0; k < QW; k++) begin
				d_s[k+1] <= d_s[k];
				dg_s[k+1] <= dg_s[k];
			end
			line_a_q <= dg_s[QW] ? '0 : res[0];
			line_b_q <= dg_s[QW] ? '0 : res[1];
			deg_q <= dg_s[QW];
			sat_q <= ~dg_s[QW] & (sat[0] | sat[1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) v_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < QW; k++) v_s[k+1] <= v_s[k];
			out_valid_q <= v_s[QW];
		end
	end

	assign out_valid = out_valid_q;
	assign line_a = line_a_q;
	assign line_b = line_b_q;
	assign degenerate = deg_q;
	assign saturated = sat_q;

endmodule

// ----- design/vlq_checker.sv -----
`timescale 1ns / 1ps
module vlq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [vlq_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [vlq_pkg::OUT_USER_W-1:0] m_tuser
);
	import vlq_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_DEG] |-> m_tdata == '0 && !m_tuser[USER_SAT])
		else $error("degenerate beat carries nonzero terms");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_SAT] |->
			m_tdata[31:0] == SAT_POS || m_tdata[31:0] == SAT_NEG ||
			m_tdata[63:32] == SAT_POS || m_tdata[63:32] == SAT_NEG)
		else $error("saturated beat without a clamped term");

endmodule

bind vanishing_line_from_quad_top vlq_checker u_vlq_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
